/* hdl/lifegen_pkg.sv */
// Shared types and constants for the toroidal life generation unit.
`timescale 1ns / 1ps
`default_nettype none

package lifegen_pkg;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Field and register widths
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned COORD_W = 6;

  // Reset value of both size registers
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // B3/S23 rule
  localparam int unsigned NB_CNT_W = 4;
  localparam logic [NB_CNT_W-1:0] SURVIVE_LO = 4'd2;
  localparam logic [NB_CNT_W-1:0] BIRTH_CNT  = 4'd3;

endpackage

`default_nettype wire

/* hdl/life_toroidal_generation_unit.sv */
// Toroidal B3/S23 life grid with cell access, clear and generation advance.
//
// Requests enter on in_valid/in_stall with op, row, col and value; each
// request yields exactly one response on out_valid/out_stall carrying
// cell_value, out_of_range and done_op. A request is taken only while the
// sequencer is idle (in_stall low); a response held by a stalled receiver
// sits in the output register while the next request is already taken.
// A read or write passes through the access state, an out-of-range access
// skips to the response, and a clear sweeps all MAX_ROWS rows. The advance
// walks the grid one row word per cycle through the single memory read port
// and one shared row update unit, so its cost follows the number of rows.
// The grid is a row-wide memory; rows and columns wrap at the sizes in use.
// The user writes the size registers through cfg_we/cfg_index/cfg_data
// only while idle, not enforced by the block. After reset, in_stall stays
// high while a clearing pass zeroes the grid; configuration writes are
// still taken. Reset sets both sizes to 64 and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module life_toroidal_generation_unit
  import lifegen_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [SIZE_W-1:0]  cfg_data,
  // request channel
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic [COORD_W-1:0] col,
  input  wire logic               value,
  // response channel
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               cell_value,
  output      logic               out_of_range,
  output      logic [1:0]         done_op
);

  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned NRW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW  = $clog2(MAX_COLS + 1);
  localparam int unsigned KW   = $clog2(MAX_ROWS + 3);
  localparam int unsigned SRW  = (NRW > SIZE_W) ? NRW : SIZE_W;
  localparam int unsigned SCW  = (NCW > SIZE_W) ? NCW : SIZE_W;
  localparam int unsigned CMRW = (NRW > COORD_W) ? NRW : COORD_W;
  localparam int unsigned CMCW = (NCW > COORD_W) ? NCW : COORD_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ADV,
    ST_DONE
  } state_t;

  typedef logic [MAX_COLS-1:0] row_t;

  state_t state;

  // configuration
  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;

  // latched request
  op_t           req_op;
  logic [RW-1:0] req_row;
  logic [CW-1:0] req_col;
  logic          req_value;
  logic          res_cell;
  logic          res_oor;
  logic          clr_report;

  // clear sweep and advance sequencer
  logic [RW-1:0] clr_addr;
  logic [KW-1:0] rd_k;
  logic          pend;
  logic          pend_saved;
  logic [KW-1:0] pend_k;
  logic          cmp_go;
  logic [RW-1:0] cmp_row;
  row_t          win_up;
  row_t          win_mid;
  row_t          win_dn;
  row_t          row0_old;

  // grid memory
  row_t          grid_mem [MAX_ROWS];
  row_t          rdata;
  logic [RW-1:0] mem_raddr;
  logic          mem_we;
  logic [RW-1:0] mem_waddr;
  row_t          mem_wdata;

  // effective sizes: zero acts as one, too large saturates
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  logic [RW-1:0]  nr_last;
  logic [CW-1:0]  nc_last;
  logic [KW-1:0]  nr_k;

  always_comb begin
    if (rows_in_use == '0) begin
      nr = NRW'(1);
    end else if (SRW'(rows_in_use) > SRW'(MAX_ROWS)) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      nc = NCW'(1);
    end else if (SCW'(cols_in_use) > SCW'(MAX_COLS)) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_in_use);
    end
  end

  assign nr_last = RW'(nr - NRW'(1));
  assign nc_last = CW'(nc - NCW'(1));
  assign nr_k    = KW'(nr);

  // coordinate check for the incoming request
  logic in_inside;
  assign in_inside = (CMRW'(row) < CMRW'(nr)) && (CMCW'(col) < CMCW'(nc));

  logic in_accept;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);

  // shared row update unit: one full row of B3/S23 from a 3-row window
  row_t up_l, up_r, mid_l, mid_r, dn_l, dn_r;
  row_t new_row;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (c == 0) begin
        up_l[c]  = win_up[nc_last];
        mid_l[c] = win_mid[nc_last];
        dn_l[c]  = win_dn[nc_last];
      end else begin
        up_l[c]  = win_up[(c + MAX_COLS - 1) % MAX_COLS];
        mid_l[c] = win_mid[(c + MAX_COLS - 1) % MAX_COLS];
        dn_l[c]  = win_dn[(c + MAX_COLS - 1) % MAX_COLS];
      end
      if (c == MAX_COLS - 1 || CW'(c) == nc_last) begin
        up_r[c]  = win_up[0];
        mid_r[c] = win_mid[0];
        dn_r[c]  = win_dn[0];
      end else begin
        up_r[c]  = win_up[(c + 1) % MAX_COLS];
        mid_r[c] = win_mid[(c + 1) % MAX_COLS];
        dn_r[c]  = win_dn[(c + 1) % MAX_COLS];
      end
    end
  end

  always_comb begin
    logic [NB_CNT_W-1:0] cnt;
    cnt = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = NB_CNT_W'(up_l[c]) + NB_CNT_W'(win_up[c]) + NB_CNT_W'(up_r[c])
          + NB_CNT_W'(mid_l[c]) + NB_CNT_W'(mid_r[c])
          + NB_CNT_W'(dn_l[c]) + NB_CNT_W'(win_dn[c]) + NB_CNT_W'(dn_r[c]);
      if (CMCW'(c) >= CMCW'(nc)) begin
        // columns beyond the size in use keep their value
        new_row[c] = win_mid[c];
      end else if (win_mid[c]) begin
        new_row[c] = (cnt == SURVIVE_LO) || (cnt == BIRTH_CNT);
      end else begin
        new_row[c] = (cnt == BIRTH_CNT);
      end
    end
  end

  // memory port control
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        mem_raddr = RW'(row);
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_ACCESS: begin
        mem_waddr = req_row;
        mem_wdata = rdata;
        mem_wdata[req_col] = req_value;
        mem_we    = (req_op == OP_WRITE);
      end
      ST_ADV: begin
        mem_raddr = (rd_k == '0) ? nr_last : RW'(rd_k - KW'(1));
        mem_we    = cmp_go;
        mem_waddr = cmp_row;
        mem_wdata = new_row;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // grid memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rdata <= grid_mem[mem_raddr];
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
  end

  // sequencer, configuration and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      clr_report  <= 1'b0;
      out_valid   <= 1'b0;
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
      pend        <= 1'b0;
      cmp_go      <= 1'b0;
      rd_k        <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default:  rows_in_use <= cfg_data;
        endcase
      end

      // response taken by the receiver; in ST_DONE the next one replaces it
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + RW'(1);
          if (clr_addr == LAST_ROW) begin
            state <= clr_report ? ST_DONE : ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_accept) begin
            req_op    <= op_t'(op);
            req_row   <= RW'(row);
            req_col   <= CW'(col);
            req_value <= value;
            res_cell  <= 1'b0;
            unique case (op_t'(op))
              OP_WRITE, OP_READ: begin
                if (in_inside) begin
                  res_oor <= 1'b0;
                  state   <= ST_ACCESS;
                end else begin
                  res_oor <= 1'b1;
                  state   <= ST_DONE;
                end
              end
              OP_ADVANCE: begin
                res_oor <= 1'b0;
                rd_k    <= '0;
                pend    <= 1'b0;
                cmp_go  <= 1'b0;
                state   <= ST_ADV;
              end
              OP_CLEAR: begin
                res_oor    <= 1'b0;
                clr_addr   <= '0;
                clr_report <= 1'b1;
                state      <= ST_CLEAR;
              end
              default: begin
                res_oor <= 1'b0;
                state   <= ST_DONE;
              end
            endcase
          end
        end

        ST_ACCESS: begin
          if (req_op == OP_READ) begin
            res_cell <= rdata[req_col];
          end
          state <= ST_DONE;
        end

        ST_ADV: begin
          // issue window rows: row nr-1, rows 0..nr-1, then saved old row 0
          if (rd_k <= nr_k + KW'(1)) begin
            pend       <= 1'b1;
            pend_k     <= rd_k;
            pend_saved <= (rd_k == nr_k + KW'(1));
            rd_k       <= rd_k + KW'(1);
          end else begin
            pend <= 1'b0;
          end
          // shift the arriving row into the window
          if (pend) begin
            win_up  <= win_mid;
            win_mid <= win_dn;
            win_dn  <= pend_saved ? row0_old : rdata;
            if (pend_k == KW'(1)) begin
              row0_old <= rdata;
            end
            cmp_go  <= (pend_k >= KW'(2));
            cmp_row <= RW'(pend_k - KW'(2));
          end else begin
            cmp_go <= 1'b0;
          end
          // last row written this cycle; issue and window are already drained
          if (cmp_go && cmp_row == nr_last) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            cell_value   <= res_cell;
            out_of_range <= res_oor;
            done_op      <= req_op;
            clr_report   <= 1'b0;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the toroidal B3/S23 life generation unit.
`timescale 1ns / 1ps

module tb_top;
  import lifegen_pkg::*;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               value;
  } life_req_t;

  typedef struct packed {
    logic cell_value;
    logic out_of_range;
    op_t  done_op;
  } life_rsp_t;

  // DUT ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_ROWS;
  logic [SIZE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = OP_WRITE;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] col = '0;
  logic               value = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               cell_value;
  logic               out_of_range;
  logic [1:0]         done_op;

  // Predictor state: grid and size registers as the block should hold them
  logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
  logic [SIZE_W-1:0]    rows_reg = SIZE_RESET;
  logic [SIZE_W-1:0]    cols_reg = SIZE_RESET;

  // Request backlog and responses still owed by the block
  life_req_t req_backlog [$];
  life_rsp_t rsp_due [$];
  life_req_t cur_req;

  // Pacing and bookkeeping
  int send_wait = 0;
  int hold_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int quiet_cycles = 0;
  int error_count = 0;
  int checked_count = 0;
  int queued_total = 0;
  int size_settings = 1;
  int live_reads = 0;
  int oor_hits = 0;
  int op_count [4] = '{0, 0, 0, 0};

  life_toroidal_generation_unit #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .row(row),
    .col(col),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_value(cell_value),
    .out_of_range(out_of_range),
    .done_op(done_op)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Size in use: zero acts as one, anything past the maximum saturates
  function automatic int span(logic [SIZE_W-1:0] reg_val, int limit);
    if (reg_val == 0) return 1;
    if (reg_val > limit) return limit;
    return int'(reg_val);
  endfunction

  // Applies one request to the grid and returns the response it should produce
  function automatic life_rsp_t life_apply(life_req_t rq);
    life_rsp_t            rs;
    int                   nr;
    int                   nc;
    int                   live;
    logic [GRID_COLS-1:0] fresh [GRID_ROWS];
    nr = span(rows_reg, GRID_ROWS);
    nc = span(cols_reg, GRID_COLS);
    rs.cell_value = 1'b0;
    rs.out_of_range = 1'b0;
    rs.done_op = rq.op;
    case (rq.op)
      OP_WRITE, OP_READ: begin
        if (rq.row >= nr || rq.col >= nc) rs.out_of_range = 1'b1;
        else if (rq.op == OP_WRITE) life_grid[rq.row][rq.col] = rq.value;
        else rs.cell_value = life_grid[rq.row][rq.col];
      end
      OP_ADVANCE: begin
        // cells beyond the size in use keep their value
        fresh = life_grid;
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            live = 0;
            // tiny grids wrap onto the same cell several times, self included
            for (int dr = 0; dr < 3; dr++)
              for (int dc = 0; dc < 3; dc++)
                if (dr != 1 || dc != 1)
                  live += int'(life_grid[(r + nr + dr - 1) % nr][(c + nc + dc - 1) % nc]);
            fresh[r][c] = life_grid[r][c] ? (live == 2 || live == 3) : (live == 3);
          end
        end
        life_grid = fresh;
      end
      default: begin
        foreach (life_grid[r]) life_grid[r] = '0;
      end
    endcase
    return rs;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Coordinate mostly inside the grid in use, sometimes anywhere in the field
  function automatic int pick_coord(int n);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic queue_req(op_t o, int r, int c, logic v);
    life_req_t rq;
    rq.op = o;
    rq.row = COORD_W'(r);
    rq.col = COORD_W'(c);
    rq.value = v;
    req_backlog.push_back(rq);
    queued_total++;
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Block is idle once nothing is queued, in flight or owed
  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || rsp_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(logic idx, logic [SIZE_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_ROWS) rows_reg = data;
    else cols_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic, mostly seeded patterns that are evolved and probed
  task automatic fill_random(int budget);
    int nr;
    int nc;
    int start;
    int kind;
    int cr;
    int cc;
    nr = span(rows_reg, GRID_ROWS);
    nc = span(cols_reg, GRID_COLS);
    start = queued_total;
    while (queued_total - start < budget) begin
      kind = $urandom_range(0, 99);
      cr = $urandom_range(0, nr - 1);
      cc = $urandom_range(0, nc - 1);
      if (kind < 55) begin
        repeat ($urandom_range(3, 10))
          queue_req(OP_WRITE, (cr + $urandom_range(0, 3)) % nr,
                    (cc + $urandom_range(0, 3)) % nc, 1'b1);
        repeat ($urandom_range(1, 3)) begin
          queue_req(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom_range(0, 1)));
          repeat ($urandom_range(2, 6))
            queue_req(OP_READ, (cr + nr - 1 + $urandom_range(0, 5)) % nr,
                      (cc + nc - 1 + $urandom_range(0, 5)) % nc,
                      1'($urandom_range(0, 1)));
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(2, 8))
          queue_req(OP_READ, pick_coord(nr), pick_coord(nc), 1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6))
          queue_req(OP_WRITE, pick_coord(nr), pick_coord(nc), 1'($urandom_range(0, 1)));
      end else if (kind < 95) begin
        queue_req(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
        queue_req(OP_READ, pick_coord(nr), pick_coord(nc), 1'($urandom_range(0, 1)));
      end else begin
        queue_req(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] rows_set, logic [SIZE_W-1:0] cols_set,
                           int budget);
    wait_idle();
    write_size(REG_ROWS, rows_set);
    write_size(REG_COLS, cols_set);
    size_settings++;
    fill_random(budget);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        rsp_due.push_back(life_apply(cur_req));
        op_count[cur_req.op]++;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          cur_req = req_backlog.pop_front();
          op <= cur_req.op;
          row <= cur_req.row;
          col <= cur_req.col;
          value <= cur_req.value;
          in_valid <= 1'b1;
          send_wait <= send_calm ? 0 : pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stalls
  always @(posedge clk) begin
    life_rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (rsp_due.size() == 0) begin
          flag_error($sformatf("response %0d with none expected: cell=%0b oor=%0b op=%0d",
                               checked_count, cell_value, out_of_range, done_op));
        end else begin
          want = rsp_due.pop_front();
          if (want.cell_value !== cell_value || want.out_of_range !== out_of_range ||
              want.done_op !== done_op)
            flag_error($sformatf({"response %0d: expected cell=%0b oor=%0b op=%0d, ",
                                  "got cell=%0b oor=%0b op=%0d"}, checked_count,
                                 want.cell_value, want.out_of_range, want.done_op,
                                 cell_value, out_of_range, done_op));
          if (want.done_op == OP_READ && want.cell_value) live_reads++;
          if (want.out_of_range) oor_hits++;
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (!recv_calm && $urandom_range(0, 7) == 0) hold_left <= pick_pause();
        if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      end
    end
  end

  // Watchdog: too long without any request or response moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] ERROR: no traffic for %0d cycles", $realtime, QUIET_LIMIT);
      $display("** life_toroidal_generation_unit: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    foreach (life_grid[r]) life_grid[r] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: corners across the wrap, a blinker, overwrite, clear
    queue_req(OP_READ, 0, 0, 1'b0);
    queue_req(OP_WRITE, 0, 0, 1'b1);
    queue_req(OP_WRITE, 63, 63, 1'b1);
    queue_req(OP_WRITE, 0, 63, 1'b1);
    queue_req(OP_WRITE, 63, 0, 1'b1);
    queue_req(OP_READ, 63, 63, 1'b0);
    queue_req(OP_READ, 0, 63, 1'b1);
    queue_req(OP_ADVANCE, 63, 0, 1'b1);
    queue_req(OP_READ, 0, 0, 1'b0);
    queue_req(OP_READ, 63, 0, 1'b0);
    queue_req(OP_READ, 1, 1, 1'b0);
    queue_req(OP_WRITE, 31, 31, 1'b1);
    queue_req(OP_WRITE, 31, 32, 1'b1);
    queue_req(OP_WRITE, 31, 33, 1'b1);
    queue_req(OP_ADVANCE, 0, 0, 1'b0);
    queue_req(OP_READ, 30, 32, 1'b0);
    queue_req(OP_READ, 32, 32, 1'b0);
    queue_req(OP_READ, 31, 31, 1'b0);
    queue_req(OP_WRITE, 0, 0, 1'b0);
    queue_req(OP_READ, 0, 0, 1'b1);
    queue_req(OP_CLEAR, 63, 63, 1'b1);
    queue_req(OP_READ, 63, 63, 1'b1);

    // size sweep: single cell, zero and oversize registers, narrow strips, random
    run_phase(7'd1, 7'd1, 100);
    run_phase(7'd0, 7'd127, 100);
    run_phase(7'd2, 7'd2, 120);
    run_phase(7'd127, 7'd0, 100);
    run_phase(7'd3, 7'd3, 150);
    run_phase(7'd5, 7'd7, 200);
    run_phase(7'd2, 7'd64, 120);
    run_phase(7'd64, 7'd2, 120);
    run_phase(7'($urandom_range(1, 20)), 7'($urandom_range(1, 20)), 250);
    run_phase(7'($urandom_range(1, 20)), 7'($urandom_range(1, 64)), 250);
    run_phase(7'd64, 7'd64, 300);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d grid sizes: %0d writes, %0d reads, %0d advances, %0d clears.",
             queued_total, size_settings, op_count[OP_WRITE], op_count[OP_READ],
             op_count[OP_ADVANCE], op_count[OP_CLEAR]);
    $display("Checked %0d responses: %0d live reads, %0d off-grid accesses, %0d mismatches.",
             checked_count, live_reads, oor_hits, error_count);
    if (error_count == 0) begin
      $display("** life_toroidal_generation_unit: PASSED **");
    end else begin
      $display("** life_toroidal_generation_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lifegen_pkg.sv
hdl/life_toroidal_generation_unit.sv
tb/tb_top.sv
